@@ hw/rtl/bmp_pkg.sv @@
// shared types, mode codes and constants for the blind motor position controller
`timescale 1ns / 1ps

package bmp_pkg;

  localparam int unsigned PosW     = 13;
  localparam int unsigned StampW   = 32;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned PercentW = 7;

  localparam logic [ModeW-1:0] MODE_IDLE = 2'd0;
  localparam logic [ModeW-1:0] MODE_WAIT = 2'd1;
  localparam logic [ModeW-1:0] MODE_DOWN = 2'd2;
  localparam logic [ModeW-1:0] MODE_UP   = 2'd3;

  localparam logic [PosW-1:0] FULL_SCALE_MS = 13'd7200;
  localparam logic [PosW-1:0] UNDERFLOW_POS = 13'd10;

  // 100 * pos / 7200 == pos / 72, done as a reciprocal multiply (exact for 13-bit pos)
  localparam int unsigned RecipShift = 19;
  localparam logic [PosW-1:0] RECIP_72 = 13'd7282;
  localparam int unsigned ProdW = 2 * PosW;

  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic [PosW-1:0]   pos;
    logic [StampW-1:0] last_stamp;
  } state_t;

  typedef struct packed {
    logic                motor_power;
    logic                motor_direction;
    logic [ModeW-1:0]    mode_code;
    logic [PercentW-1:0] position_percent;
  } result_t;

  function automatic logic [PercentW-1:0] pos_to_percent(input logic [PosW-1:0] pos);
    logic [ProdW-1:0] prod;
    prod = {{PosW{1'b0}}, pos} * {{PosW{1'b0}}, RECIP_72};
    return prod[RecipShift +: PercentW];
  endfunction

endpackage

@@ hw/rtl/bmp_step.sv @@
// per-poll mode update, travel accumulate and result formatting
`timescale 1ns / 1ps

module bmp_step (
  input  logic                        button_one,
  input  logic                        button_two,
  input  logic [bmp_pkg::StampW-1:0]  now_ms,
  input  logic [bmp_pkg::PosW-1:0]    max_travel_ms,
  input  bmp_pkg::state_t             state,
  output bmp_pkg::state_t             state_next,
  output bmp_pkg::result_t            result
);

  logic [bmp_pkg::StampW-1:0] elapsed;
  logic [bmp_pkg::StampW:0]   up_sum;
  logic [bmp_pkg::PosW-1:0]   up_pos;
  logic [bmp_pkg::PosW-1:0]   down_diff;
  logic [bmp_pkg::PosW-1:0]   down_pos;

  assign elapsed = now_ms - state.last_stamp;

  // increasing travel, saturate at the maximum
  assign up_sum = {{(bmp_pkg::StampW + 1 - bmp_pkg::PosW){1'b0}}, state.pos}
                + {1'b0, elapsed};
  assign up_pos = (up_sum > {{(bmp_pkg::StampW + 1 - bmp_pkg::PosW){1'b0}}, max_travel_ms})
                ? max_travel_ms : up_sum[bmp_pkg::PosW-1:0];

  // decreasing travel, below zero lands on the underflow value, above the maximum clamps to it
  assign down_diff = state.pos - elapsed[bmp_pkg::PosW-1:0];
  always_comb begin
    if (elapsed > {{(bmp_pkg::StampW - bmp_pkg::PosW){1'b0}}, state.pos}) begin
      down_pos = bmp_pkg::UNDERFLOW_POS;
    end else if (down_diff > max_travel_ms) begin
      down_pos = max_travel_ms;
    end else begin
      down_pos = down_diff;
    end
  end

  always_comb begin
    state_next = state;
    case (state.mode)
      bmp_pkg::MODE_IDLE: begin
        if (!button_one && button_two) begin
          state_next.mode       = bmp_pkg::MODE_UP;
          state_next.last_stamp = now_ms;
        end else if (button_one && !button_two) begin
          state_next.mode       = bmp_pkg::MODE_DOWN;
          state_next.last_stamp = now_ms;
        end
      end
      bmp_pkg::MODE_WAIT: begin
        if (!button_one && !button_two) begin
          state_next.mode       = bmp_pkg::MODE_IDLE;
          state_next.last_stamp = now_ms;
        end
      end
      bmp_pkg::MODE_DOWN: begin
        if (!button_one && button_two) begin
          state_next.mode = bmp_pkg::MODE_WAIT;
        end else if (!button_one && !button_two) begin
          state_next.mode = bmp_pkg::MODE_IDLE;
        end
        state_next.pos        = down_pos;
        state_next.last_stamp = now_ms;
      end
      bmp_pkg::MODE_UP: begin
        if (!button_one && !button_two) begin
          state_next.mode = bmp_pkg::MODE_IDLE;
        end else if (button_one && !button_two) begin
          state_next.mode = bmp_pkg::MODE_WAIT;
        end
        state_next.pos        = up_pos;
        state_next.last_stamp = now_ms;
      end
      default: begin
        state_next = state;
      end
    endcase
  end

  assign result.motor_power      = state_next.mode[1];
  assign result.motor_direction  = (state_next.mode == bmp_pkg::MODE_UP);
  assign result.mode_code        = state_next.mode;
  assign result.position_percent = bmp_pkg::pos_to_percent(state_next.pos);

endmodule

@@ hw/rtl/blind_motor_position_fsm_top.sv @@
// top level of the blind motor position controller: poll register, state and result register
`timescale 1ns / 1ps

// channel  | handshake                  | beat contents
// poll in  | in_valid / in_stall        | button_one, button_two, now_ms
// result   | out_valid / out_stall      | motor_power, motor_direction, mode_code,
//          |                            | position_percent
// config   | cfg_valid / cfg_ready      | cfg_data (max_travel_ms)
//
// one poll per cycle sustained while out_stall is low; a taken poll goes through the poll
// register, then the result register; the path that sets the cycle is the 32-bit elapsed
// subtract plus the saturating accumulate and the reciprocal percent multiply, between them
// reset: idle mode, position 0, stamp 0, max travel 7200; config is always ready
// out_stall holds the result register and backs up into in_stall in the same cycle

module blind_motor_position_fsm_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         button_one,
  input  logic                         button_two,
  input  logic [bmp_pkg::StampW-1:0]   now_ms,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         motor_power,
  output logic                         motor_direction,
  output logic [bmp_pkg::ModeW-1:0]    mode_code,
  output logic [bmp_pkg::PercentW-1:0] position_percent,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bmp_pkg::PosW-1:0]     cfg_data
);

  logic                       s1_valid;
  logic                       s1_one;
  logic                       s1_two;
  logic [bmp_pkg::StampW-1:0] s1_now;
  logic [bmp_pkg::PosW-1:0]   max_travel;
  bmp_pkg::state_t            state;
  bmp_pkg::state_t            state_next;
  bmp_pkg::result_t           result_next;
  bmp_pkg::result_t           result;
  logic                       out_free;
  logic                       s1_fire;

  assign out_free  = !out_valid || !out_stall;
  assign s1_fire   = s1_valid && out_free;
  assign in_stall  = s1_valid && !out_free;
  assign cfg_ready = 1'b1;

  bmp_step u_step (
    .button_one    (s1_one),
    .button_two    (s1_two),
    .now_ms        (s1_now),
    .max_travel_ms (max_travel),
    .state         (state),
    .state_next    (state_next),
    .result        (result_next)
  );

  // poll register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_one <= button_one;
      s1_two <= button_two;
      s1_now <= now_ms;
    end
  end

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode       <= bmp_pkg::MODE_IDLE;
      state.pos        <= '0;
      state.last_stamp <= '0;
    end else if (s1_fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_travel <= bmp_pkg::FULL_SCALE_MS;
    end else if (cfg_valid && cfg_ready) begin
      max_travel <= cfg_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      result <= result_next;
    end
  end

  assign motor_power      = result.motor_power;
  assign motor_direction  = result.motor_direction;
  assign mode_code        = result.mode_code;
  assign position_percent = result.position_percent;

`ifndef ASSERT_OFF
  a_still_pos: assert property (@(posedge clk) disable iff (rst)
    s1_fire && !state.mode[1] |=> $stable(state.pos))
    else $error("travel position moved on a poll outside a moving mode");

  a_power_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (motor_power == mode_code[1]) &&
                  (motor_direction == (mode_code == bmp_pkg::MODE_UP)))
    else $error("relay outputs disagree with the mode code");

  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> position_percent <= 7'd113)
    else $error("position percent out of range");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("poll side stalled with room in the pipe");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !s1_fire |=> $stable(state))
    else $error("controller state changed without a poll");
`endif

endmodule

@@ verif/tb_blind_motor_position_fsm_top.sv @@
// self-checking testbench for the blind motor position controller top level
`timescale 1ns / 1ps

module tb_blind_motor_position_fsm_top;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned IdlePct    = 18;
  localparam int unsigned HoldCycles = 60;

  typedef struct {
    logic                       b1;
    logic                       b2;
    logic [bmp_pkg::StampW-1:0] stamp;
  } poll_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic                         button_one = 1'b0;
  logic                         button_two = 1'b0;
  logic [bmp_pkg::StampW-1:0]   now_ms = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic                         motor_power;
  logic                         motor_direction;
  logic [bmp_pkg::ModeW-1:0]    mode_code;
  logic [bmp_pkg::PercentW-1:0] position_percent;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [bmp_pkg::PosW-1:0]     cfg_data = '0;

  // blind state as the testbench sees it
  logic [bmp_pkg::ModeW-1:0]  blind_mode  = bmp_pkg::MODE_IDLE;
  logic [bmp_pkg::PosW-1:0]   blind_pos   = '0;
  logic [bmp_pkg::StampW-1:0] blind_stamp = '0;
  logic [bmp_pkg::PosW-1:0]   travel_max  = bmp_pkg::FULL_SCALE_MS;

  poll_t             poll_q[$];
  poll_t             held_poll;
  bmp_pkg::result_t  status_q[$];
  int unsigned       polls_queued = 0;
  int unsigned       polls_taken  = 0;
  int unsigned       results_seen = 0;
  int unsigned       mismatches   = 0;
  int unsigned       hold_left    = 0;
  int unsigned       cycles       = 0;
  logic [bmp_pkg::StampW-1:0] clock_ms = '0;

  blind_motor_position_fsm_top DUT (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .button_one       (button_one),
    .button_two       (button_two),
    .now_ms           (now_ms),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .motor_power      (motor_power),
    .motor_direction  (motor_direction),
    .mode_code        (mode_code),
    .position_percent (position_percent),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("** blind_motor_position_fsm_top: FAILED **");
      $finish;
    end
  end

  // travel accumulate with saturation at the max and the jump to 10 below zero
  function automatic void move_blind(input logic up,
                                     input logic [bmp_pkg::StampW-1:0] stamp);
    logic [bmp_pkg::StampW-1:0] elapsed;
    longint                     pos;
    elapsed = stamp - blind_stamp;
    pos = longint'(blind_pos);
    if (up) pos = pos + longint'(elapsed);
    else pos = pos - longint'(elapsed);
    if (pos > longint'(travel_max)) pos = longint'(travel_max);
    else if (pos < 0) pos = longint'(bmp_pkg::UNDERFLOW_POS);
    blind_pos   = pos[bmp_pkg::PosW-1:0];
    blind_stamp = stamp;
  endfunction

  function automatic bmp_pkg::result_t advance_blind(input poll_t p);
    bmp_pkg::result_t r;
    int unsigned      pct;
    case (blind_mode)
      bmp_pkg::MODE_IDLE: begin
        if (!p.b1 && p.b2) begin
          blind_mode  = bmp_pkg::MODE_UP;
          blind_stamp = p.stamp;
        end else if (p.b1 && !p.b2) begin
          blind_mode  = bmp_pkg::MODE_DOWN;
          blind_stamp = p.stamp;
        end
      end
      bmp_pkg::MODE_WAIT: begin
        if (!p.b1 && !p.b2) begin
          blind_mode  = bmp_pkg::MODE_IDLE;
          blind_stamp = p.stamp;
        end
      end
      bmp_pkg::MODE_DOWN: begin
        if (!p.b1 && p.b2) blind_mode = bmp_pkg::MODE_WAIT;
        else if (!p.b1 && !p.b2) blind_mode = bmp_pkg::MODE_IDLE;
        move_blind(1'b0, p.stamp);
      end
      default: begin
        if (!p.b1 && !p.b2) blind_mode = bmp_pkg::MODE_IDLE;
        else if (p.b1 && !p.b2) blind_mode = bmp_pkg::MODE_WAIT;
        move_blind(1'b1, p.stamp);
      end
    endcase
    pct = 32'((100 * int'(blind_pos)) / int'(bmp_pkg::FULL_SCALE_MS));
    r.motor_power      = (blind_mode == bmp_pkg::MODE_DOWN) ||
                         (blind_mode == bmp_pkg::MODE_UP);
    r.motor_direction  = (blind_mode == bmp_pkg::MODE_UP);
    r.mode_code        = blind_mode;
    r.position_percent = pct[bmp_pkg::PercentW-1:0];
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        status_q.push_back(advance_blind(held_poll));
        polls_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (poll_q.size() != 0 &&
            ((polls_taken >= 400 && polls_taken < 600) || $urandom_range(99, 0) >= IdlePct)) begin
          held_poll = poll_q.pop_front();
          in_valid   <= 1'b1;
          button_one <= held_poll.b1;
          button_two <= held_poll.b2;
          now_ms     <= held_poll.stamp;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void compare_field(input string field, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endfunction

  // monitor
  always @(posedge clk) begin
    bmp_pkg::result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (status_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual mode %0d percent %0d",
                   $time, mode_code, position_percent);
          mismatches++;
        end else begin
          want = status_q.pop_front();
          compare_field("motor_power", 32'(want.motor_power), 32'(motor_power));
          compare_field("motor_direction", 32'(want.motor_direction),
                        32'(motor_direction));
          compare_field("mode_code", 32'(want.mode_code), 32'(mode_code));
          compare_field("position_percent", 32'(want.position_percent),
                        32'(position_percent));
        end
        // long hold-off so the block backs up into its input
        if (results_seen == 300 || results_seen == 900) hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (results_seen >= 500 && results_seen < 700) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99, 0) < IdlePct);
      end
    end
  end

  task automatic queue_poll(input logic b1, input logic b2,
                            input logic [bmp_pkg::StampW-1:0] stamp);
    poll_t p;
    p.b1    = b1;
    p.b2    = b2;
    p.stamp = stamp;
    poll_q.push_back(p);
    polls_queued++;
  endtask

  function automatic logic [bmp_pkg::StampW-1:0] next_stamp();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 3) clock_ms = $urandom();
    else if (r < 13) clock_ms = clock_ms + $urandom_range(9000, 0);
    else clock_ms = clock_ms + $urandom_range(300, 0);
    return clock_ms;
  endfunction

  task automatic wait_drained();
    while (polls_taken != polls_queued || status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max(input logic [bmp_pkg::PosW-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    travel_max = value;
    cfg_valid <= 1'b0;
  endtask

  // press one button, hold it, then release, reverse into wait, or leave it moving
  task automatic queue_press_run();
    logic       down;
    logic [1:0] held;
    int         ending;
    down = 1'($urandom_range(1, 0));
    queue_poll(down, !down, next_stamp());
    repeat ($urandom_range(12, 1)) begin
      if ($urandom_range(99, 0) < 20) queue_poll(1'b1, 1'b1, next_stamp());
      else queue_poll(down, !down, next_stamp());
    end
    ending = int'($urandom_range(2, 0));
    if (ending == 0) begin
      queue_poll(1'b0, 1'b0, next_stamp());
    end else if (ending == 1) begin
      queue_poll(!down, down, next_stamp());
      repeat ($urandom_range(3, 0)) begin
        held = 2'($urandom_range(3, 1));
        queue_poll(held[0], held[1], next_stamp());
      end
      queue_poll(1'b0, 1'b0, next_stamp());
    end
  endtask

  task automatic run_phase(input int unsigned count);
    int unsigned first;
    first = polls_queued;
    queue_poll(1'b0, 1'b0, next_stamp());
    while (polls_queued - first < count) begin
      if ($urandom_range(99, 0) < 80) begin
        queue_press_run();
      end else begin
        repeat ($urandom_range(3, 1))
          queue_poll(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)), next_stamp());
      end
    end
    wait_drained();
  endtask

  initial begin
    logic [bmp_pkg::PosW-1:0] max_list[7];
    max_list = '{13'd3000, 13'd0, 13'd8191, 13'd5, bmp_pkg::FULL_SCALE_MS,
                 13'($urandom_range(8191, 0)), 13'd10};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: idle holds, up with saturation, reversal into wait, down past zero,
    // stamp wrap, release while moving
    queue_poll(1'b0, 1'b0, 32'd0);
    queue_poll(1'b1, 1'b1, 32'd5);
    queue_poll(1'b0, 1'b1, 32'd100);
    queue_poll(1'b1, 1'b1, 32'd3000);
    queue_poll(1'b0, 1'b1, 32'd20000);
    queue_poll(1'b1, 1'b0, 32'd20010);
    queue_poll(1'b1, 1'b1, 32'd20020);
    queue_poll(1'b0, 1'b0, 32'd20030);
    queue_poll(1'b1, 1'b0, 32'd20040);
    queue_poll(1'b1, 1'b1, 32'd21040);
    queue_poll(1'b1, 1'b0, 32'hFFFF_FFF0);
    queue_poll(1'b1, 1'b0, 32'h0000_0010);
    queue_poll(1'b0, 1'b1, 32'h0000_0015);
    queue_poll(1'b0, 1'b0, 32'h0000_0020);
    queue_poll(1'b0, 1'b1, 32'hFFFF_FFFF);
    queue_poll(1'b0, 1'b1, 32'h0000_0064);
    queue_poll(1'b0, 1'b0, 32'h8000_0000);
    queue_poll(1'b1, 1'b0, 32'h8000_0001);
    queue_poll(1'b0, 1'b0, 32'h8000_0002);
    clock_ms = 32'h8000_0002;
    wait_drained();

    // position is near full here, so the first max write lowers it below the position
    foreach (max_list[i]) begin
      write_max(max_list[i]);
      run_phase(175);
    end

    if (mismatches == 0) begin
      $display("** blind_motor_position_fsm_top: PASSED **");
    end else begin
      $display("** blind_motor_position_fsm_top: FAILED **");
    end
    $finish;
  end

endmodule
